@@ src/clcd_pkg.sv @@
// Shared types, codes and constants for the character LCD command sequencer.
package clcd_pkg;

   localparam logic [3:0] KIND_INIT      = 4'd0;
   localparam logic [3:0] KIND_DISP_ON   = 4'd1;
   localparam logic [3:0] KIND_DISP_OFF  = 4'd2;
   localparam logic [3:0] KIND_CLEAR     = 4'd3;
   localparam logic [3:0] KIND_HOME      = 4'd4;
   localparam logic [3:0] KIND_CURS_ON   = 4'd5;
   localparam logic [3:0] KIND_CURS_OFF  = 4'd6;
   localparam logic [3:0] KIND_BLINK_ON  = 4'd7;
   localparam logic [3:0] KIND_BLINK_OFF = 4'd8;
   localparam logic [3:0] KIND_SHIFT     = 4'd9;
   localparam logic [3:0] KIND_SETPOS    = 4'd10;
   localparam logic [3:0] KIND_CHAR      = 4'd11;
   localparam logic [3:0] KIND_RAWCMD    = 4'd12;
   localparam logic [3:0] KIND_RAWDATA   = 4'd13;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_FLAGS = 2'd1;
   localparam logic [1:0] ST_BAD_POS   = 2'd2;

   localparam logic [7:0] LCD_CLEAR      = 8'h01;
   localparam logic [7:0] LCD_HOME       = 8'h02;
   localparam logic [7:0] LCD_ENTRY_INC  = 8'h06;
   localparam logic [7:0] LCD_DISP_CTRL  = 8'h08;
   localparam logic [7:0] LCD_SHIFT_CTRL = 8'h10;
   localparam logic [7:0] LCD_SHIFT_RIGHT = 8'h04;
   localparam logic [7:0] LCD_FUNC_2LINE = 8'h28;

   localparam logic [2:0] MODE_ON     = 3'h4;
   localparam logic [2:0] MODE_CURSOR = 3'h2;
   localparam logic [2:0] MODE_BLINK  = 3'h1;

   localparam logic [3:0] INIT_LAST = 4'd11;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_INIT,
      OP_STATUS
   } op_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [2:0] mode_flags;
      logic       move_right;
      logic [1:0] target_row;
      logic [5:0] target_col;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic       drive;
      logic       reg_select;
      logic [3:0] nibble;
      logic       strobe_res;
      logic [1:0] status;
      logic       last;
      logic       cursor_row_out;
      logic [4:0] cursor_col_out;
      logic [2:0] display_mode_out;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic       rs;
      logic [7:0] value;
      logic [1:0] status;
      logic       row;
      logic [4:0] col;
      logic [2:0] mode;
   } desc_type;

   function automatic logic [3:0] init_nibble(input logic [3:0] idx);
      logic [3:0] nib;
      case (idx)
         4'd0, 4'd1, 4'd2: nib = 4'h3;
         4'd3:             nib = 4'h2;
         4'd4:             nib = LCD_FUNC_2LINE[7:4];
         4'd5:             nib = LCD_FUNC_2LINE[3:0];
         4'd6:             nib = LCD_DISP_CTRL[7:4];
         4'd7:             nib = LCD_DISP_CTRL[3:0];
         4'd8:             nib = LCD_CLEAR[7:4];
         4'd9:             nib = LCD_CLEAR[3:0];
         4'd10:            nib = LCD_ENTRY_INC[7:4];
         4'd11:            nib = LCD_ENTRY_INC[3:0];
         default:          nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

@@ src/char_lcd_command_sequencer_top.sv @@
// Top level of the character LCD command sequencer (4-bit bus writes).
//
//   port group | dir | payload            | handshake
//   req_       | in  | clcd_pkg::req_type | req_valid / req_stall
//   rsp_       | out | clcd_pkg::rsp_type | rsp_valid / rsp_stall
//
// A command is decoded in the cycle it is accepted and, if known, its descriptor is queued.
// The sequencer issues one transaction per cycle unless rsp_stall holds it: two for a byte
// command, twelve for init, one for a rejected command; unknown kinds give nothing.
// An accepted descriptor is written into the queue, then loaded into the output register.
// req_stall rises only while the queue is full; rsp_stall holds the output register.
// Reset clears cursor, mode, queue and sequencer.
module char_lcd_command_sequencer_top #(
   parameter int COLUMNS     = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output clcd_pkg::rsp_type rsp_data
);

   logic               accept;
   logic               push;
   logic               full;
   logic               pop;
   logic               not_empty;
   clcd_pkg::desc_type push_desc;
   clcd_pkg::desc_type head_desc;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   clcd_front #(
      .COLUMNS(COLUMNS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .push  (push),
      .desc  (push_desc)
   );

   clcd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_desc(push_desc),
      .full     (full),
      .pop      (pop),
      .not_empty(not_empty),
      .head_desc(head_desc)
   );

   clcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .desc_valid(not_empty),
      .desc      (head_desc),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/clcd_front.sv @@
// Command decoder: validates commands, tracks cursor and mode, builds bus descriptors.
module clcd_front #(
   parameter int COLUMNS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  clcd_pkg::req_type req,
   output logic              push,
   output clcd_pkg::desc_type desc
);

   localparam int COL_W = $clog2(COLUMNS + 1);

   logic             row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [2:0]       mode_ff, mode_in;
   logic             valid_cmd;
   logic             rejected;
   logic [5:0]       col_wide;

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      mode_in   = mode_ff;
      valid_cmd = 1'b1;
      rejected  = 1'b0;
      desc      = '0;
      desc.op   = clcd_pkg::OP_BYTE;
      desc.status = clcd_pkg::ST_OK;
      unique case (req.kind)
         clcd_pkg::KIND_INIT: begin
            desc.op = clcd_pkg::OP_INIT;
            row_in  = 1'b0;
            col_in  = '0;
            mode_in = '0;
         end
         clcd_pkg::KIND_DISP_ON: begin
            if (req.mode_flags[2]) begin
               rejected    = 1'b1;
               desc.status = clcd_pkg::ST_BAD_FLAGS;
            end else begin
               row_in  = 1'b0;
               col_in  = '0;
               mode_in = clcd_pkg::MODE_ON | req.mode_flags;
            end
         end
         clcd_pkg::KIND_DISP_OFF:  mode_in = '0;
         clcd_pkg::KIND_CLEAR: begin
            row_in     = 1'b0;
            col_in     = '0;
            desc.value = clcd_pkg::LCD_CLEAR;
         end
         clcd_pkg::KIND_HOME: begin
            row_in     = 1'b0;
            col_in     = '0;
            desc.value = clcd_pkg::LCD_HOME;
         end
         clcd_pkg::KIND_CURS_ON:   mode_in = clcd_pkg::MODE_ON | clcd_pkg::MODE_CURSOR;
         clcd_pkg::KIND_CURS_OFF:  mode_in = clcd_pkg::MODE_ON;
         clcd_pkg::KIND_BLINK_ON:
            mode_in = clcd_pkg::MODE_ON | clcd_pkg::MODE_CURSOR | clcd_pkg::MODE_BLINK;
         clcd_pkg::KIND_BLINK_OFF: mode_in = clcd_pkg::MODE_ON | clcd_pkg::MODE_CURSOR;
         clcd_pkg::KIND_SHIFT: begin
            if ((!req.move_right && col_ff == '0) ||
                (req.move_right && col_ff >= COL_W'(COLUMNS - 1))) begin
               rejected    = 1'b1;
               desc.status = clcd_pkg::ST_BAD_POS;
            end else begin
               col_in     = req.move_right ? col_ff + COL_W'(1) : col_ff - COL_W'(1);
               desc.value = clcd_pkg::LCD_SHIFT_CTRL |
                            (req.move_right ? clcd_pkg::LCD_SHIFT_RIGHT : 8'h00);
            end
         end
         clcd_pkg::KIND_SETPOS: begin
            if (req.target_row[1] || req.target_col > 6'(COLUMNS - 1)) begin
               rejected    = 1'b1;
               desc.status = clcd_pkg::ST_BAD_POS;
            end else begin
               row_in     = req.target_row[0];
               col_in     = COL_W'(req.target_col);
               desc.value = {1'b1, req.target_row[0], req.target_col};
            end
         end
         clcd_pkg::KIND_CHAR: begin
            if (col_ff > COL_W'(COLUMNS - 1)) begin
               rejected    = 1'b1;
               desc.status = clcd_pkg::ST_BAD_POS;
            end else begin
               col_in     = col_ff + COL_W'(1);
               desc.rs    = 1'b1;
               desc.value = req.byte_value;
            end
         end
         clcd_pkg::KIND_RAWCMD:  desc.value = req.byte_value;
         clcd_pkg::KIND_RAWDATA: begin
            desc.rs    = 1'b1;
            desc.value = req.byte_value;
         end
         default: valid_cmd = 1'b0;
      endcase

      if (req.kind == clcd_pkg::KIND_DISP_ON || req.kind == clcd_pkg::KIND_DISP_OFF ||
          req.kind == clcd_pkg::KIND_CURS_ON || req.kind == clcd_pkg::KIND_CURS_OFF ||
          req.kind == clcd_pkg::KIND_BLINK_ON || req.kind == clcd_pkg::KIND_BLINK_OFF)
         desc.value = clcd_pkg::LCD_DISP_CTRL | {5'b0, mode_in};

      col_wide = 6'(col_in);
      if (rejected) begin
         desc.op    = clcd_pkg::OP_STATUS;
         desc.value = '0;
         row_in     = row_ff;
         col_in     = col_ff;
         mode_in    = mode_ff;
      end else begin
         desc.row  = row_in;
         desc.col  = col_wide[4:0];
         desc.mode = mode_in;
      end
      push = accept && valid_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= 1'b0;
         col_ff  <= '0;
         mode_ff <= '0;
      end else if (push) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         mode_ff <= mode_in;
      end
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(COLUMNS))
      else $error("tracked column beyond display width");

endmodule

@@ src/clcd_queue.sv @@
// Short descriptor queue between the decoder and the bus sequencer.
module clcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  clcd_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output clcd_pkg::desc_type head_desc
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   clcd_pkg::desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_desc = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)
         count_in = count_ff + CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("descriptor queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("descriptor queue count out of range");

endmodule

@@ src/clcd_back.sv @@
// Bus sequencer: expands descriptors to nibble writes or status, registered output.
module clcd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_valid,
   input  clcd_pkg::desc_type desc,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output clcd_pkg::rsp_type  rsp_data
);

   logic              rsp_valid_ff;
   clcd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [3:0]        step_ff, step_in;
   logic              load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign load      = desc_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_data_in                  = '0;
      rsp_data_in.drive            = desc.op != clcd_pkg::OP_STATUS;
      rsp_data_in.strobe_res       = desc.op != clcd_pkg::OP_STATUS;
      rsp_data_in.reg_select       = desc.rs;
      rsp_data_in.status           = desc.status;
      rsp_data_in.cursor_row_out   = desc.row;
      rsp_data_in.cursor_col_out   = desc.col;
      rsp_data_in.display_mode_out = desc.mode;
      unique case (desc.op)
         clcd_pkg::OP_BYTE: begin
            rsp_data_in.nibble = step_ff[0] ? desc.value[3:0] : desc.value[7:4];
            rsp_data_in.last   = step_ff[0];
         end
         clcd_pkg::OP_INIT: begin
            rsp_data_in.nibble = clcd_pkg::init_nibble(step_ff);
            rsp_data_in.last   = step_ff == clcd_pkg::INIT_LAST;
         end
         clcd_pkg::OP_STATUS: begin
            rsp_data_in.reg_select = 1'b0;
            rsp_data_in.last       = 1'b1;
         end
         default: rsp_data_in.last = 1'b1;
      endcase
      pop     = load && rsp_data_in.last;
      step_in = step_ff;
      if (load)
         step_in = rsp_data_in.last ? 4'd0 : step_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         step_ff <= step_in;
         if (load)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load)
         rsp_data_ff <= rsp_data_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= clcd_pkg::INIT_LAST)
      else $error("sequencer step out of range");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.drive |-> rsp_data_ff.last && rsp_data_ff.nibble == 4'h0)
      else $error("status transaction not a lone final result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the character LCD command sequencer (4-bit bus writes).
module tb;

   localparam int COLUMNS = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES = 200;
   localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
   localparam logic [7:0] ROW1_BASE = 8'h40;
   localparam logic [3:0] KIND_RSVD_14 = 4'd14;
   localparam logic [3:0] KIND_RSVD_15 = 4'd15;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   clcd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   clcd_pkg::rsp_type rsp_data;

   // tracked LCD state as the sequencer should see it
   logic       cur_row;
   int         cur_col;
   logic [2:0] cur_mode;

   clcd_pkg::rsp_type expected_writes[$];
   clcd_pkg::rsp_type burst[$];
   clcd_pkg::rsp_type want;
   int      mismatches = 0;
   int      quiet = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      hold_left = 0;
   logic    hold_req = 1'b0;
   logic    hold_done = 1'b0;

   char_lcd_command_sequencer_top #(.COLUMNS(COLUMNS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic clcd_pkg::req_type cmd(logic [3:0] k, logic [2:0] f, logic r,
                                             logic [1:0] row, logic [5:0] col,
                                             logic [7:0] b);
      clcd_pkg::req_type c;
      c.kind       = k;
      c.mode_flags = f;
      c.move_right = r;
      c.target_row = row;
      c.target_col = col;
      c.byte_value = b;
      return c;
   endfunction

   function automatic void add_nibble(logic rs, logic [3:0] nib);
      clcd_pkg::rsp_type w;
      w = '0;
      w.drive      = 1'b1;
      w.reg_select = rs;
      w.nibble     = nib;
      w.strobe_res = 1'b1;
      w.status     = clcd_pkg::ST_OK;
      burst.push_back(w);
   endfunction

   function automatic void add_byte(logic rs, logic [7:0] b);
      add_nibble(rs, b[7:4]);
      add_nibble(rs, b[3:0]);
   endfunction

   function automatic void apply_mode(logic [2:0] m);
      cur_mode = m;
      add_byte(1'b0, clcd_pkg::LCD_DISP_CTRL | {5'd0, m});
   endfunction

   function automatic void predict_bus_writes(clcd_pkg::req_type c);
      logic [1:0]        code;
      clcd_pkg::rsp_type w;
      code = clcd_pkg::ST_OK;
      burst.delete();
      case (c.kind)
         clcd_pkg::KIND_INIT: begin
            add_nibble(1'b0, 4'h3);
            add_nibble(1'b0, 4'h3);
            add_nibble(1'b0, 4'h3);
            add_nibble(1'b0, 4'h2);
            add_byte(1'b0, clcd_pkg::LCD_FUNC_2LINE);
            add_byte(1'b0, clcd_pkg::LCD_DISP_CTRL);
            add_byte(1'b0, clcd_pkg::LCD_CLEAR);
            add_byte(1'b0, clcd_pkg::LCD_ENTRY_INC);
            cur_row  = 1'b0;
            cur_col  = 0;
            cur_mode = 3'd0;
         end
         clcd_pkg::KIND_DISP_ON: begin
            if (c.mode_flags > (clcd_pkg::MODE_CURSOR | clcd_pkg::MODE_BLINK)) begin
               code = clcd_pkg::ST_BAD_FLAGS;
            end else begin
               cur_row = 1'b0;
               cur_col = 0;
               apply_mode(clcd_pkg::MODE_ON | c.mode_flags);
            end
         end
         clcd_pkg::KIND_DISP_OFF:  apply_mode(3'd0);
         clcd_pkg::KIND_CLEAR: begin
            cur_row = 1'b0;
            cur_col = 0;
            add_byte(1'b0, clcd_pkg::LCD_CLEAR);
         end
         clcd_pkg::KIND_HOME: begin
            cur_row = 1'b0;
            cur_col = 0;
            add_byte(1'b0, clcd_pkg::LCD_HOME);
         end
         clcd_pkg::KIND_CURS_ON:   apply_mode(clcd_pkg::MODE_ON | clcd_pkg::MODE_CURSOR);
         clcd_pkg::KIND_CURS_OFF:  apply_mode(clcd_pkg::MODE_ON);
         clcd_pkg::KIND_BLINK_ON:
            apply_mode(clcd_pkg::MODE_ON | clcd_pkg::MODE_CURSOR | clcd_pkg::MODE_BLINK);
         clcd_pkg::KIND_BLINK_OFF: apply_mode(clcd_pkg::MODE_ON | clcd_pkg::MODE_CURSOR);
         clcd_pkg::KIND_SHIFT: begin
            if ((!c.move_right && cur_col == 0) || (c.move_right && cur_col >= COLUMNS - 1)) begin
               code = clcd_pkg::ST_BAD_POS;
            end else begin
               cur_col = c.move_right ? cur_col + 1 : cur_col - 1;
               add_byte(1'b0, clcd_pkg::LCD_SHIFT_CTRL |
                        (c.move_right ? clcd_pkg::LCD_SHIFT_RIGHT : 8'h00));
            end
         end
         clcd_pkg::KIND_SETPOS: begin
            if (c.target_row > 2'd1 || int'(c.target_col) > COLUMNS - 1) begin
               code = clcd_pkg::ST_BAD_POS;
            end else begin
               cur_row = c.target_row[0];
               cur_col = int'(c.target_col);
               add_byte(1'b0, LCD_SET_DDRAM | (({2'b00, c.target_col} +
                        (c.target_row[0] ? ROW1_BASE : 8'h00)) & 8'h7F));
            end
         end
         clcd_pkg::KIND_CHAR: begin
            if (cur_col > COLUMNS - 1) begin
               code = clcd_pkg::ST_BAD_POS;
            end else begin
               add_byte(1'b1, c.byte_value);
               cur_col = cur_col + 1;
            end
         end
         clcd_pkg::KIND_RAWCMD:  add_byte(1'b0, c.byte_value);
         clcd_pkg::KIND_RAWDATA: add_byte(1'b1, c.byte_value);
         default: ;
      endcase
      if (code != clcd_pkg::ST_OK) begin
         w = '0;
         w.status = code;
         w.last   = 1'b1;
         expected_writes.push_back(w);
      end else begin
         foreach (burst[i]) begin
            w = burst[i];
            w.last             = (i == burst.size() - 1);
            w.cursor_row_out   = cur_row;
            w.cursor_col_out   = cur_col[4:0];
            w.display_mode_out = cur_mode;
            expected_writes.push_back(w);
         end
      end
   endfunction

   function automatic string show(clcd_pkg::rsp_type r);
      return $sformatf("drv=%0d rs=%0d nib=%h stb=%0d st=%0d last=%0d row=%0d col=%0d mode=%0d",
                       r.drive, r.reg_select, r.nibble, r.strobe_res, r.status, r.last,
                       r.cursor_row_out, r.cursor_col_out, r.display_mode_out);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected transaction at %0t: %s", $time, show(rsp_data));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: mismatch at %0t", $time);
                  $display("  expected %s", show(want));
                  $display("  actual   %s", show(rsp_data));
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet = 0;
      else
         quiet = quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic issue_command(input clcd_pkg::req_type c);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = c;
      do @(posedge clock); while (req_stall);
      predict_bus_writes(c);
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_commands();
      idle_pct  = 0;
      stall_pct = 0;
      issue_command(cmd(clcd_pkg::KIND_INIT, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_DISP_ON, 3'd7, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_DISP_ON, 3'd4, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_DISP_ON, 3'd3, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_DISP_ON, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_DISP_OFF, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_CURS_ON, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_CURS_OFF, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_BLINK_ON, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_BLINK_OFF, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      // left edge, right edge, then past the last column
      issue_command(cmd(clcd_pkg::KIND_SHIFT, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_SETPOS, 3'd0, 1'b0, 2'd1, 6'd15, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_SHIFT, 3'd0, 1'b1, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_CHAR, 3'd0, 1'b0, 2'd0, 6'd0, 8'hFF));
      issue_command(cmd(clcd_pkg::KIND_CHAR, 3'd0, 1'b0, 2'd0, 6'd0, 8'h41));
      issue_command(cmd(clcd_pkg::KIND_SHIFT, 3'd0, 1'b1, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_SHIFT, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_SETPOS, 3'd0, 1'b0, 2'd2, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_SETPOS, 3'd0, 1'b0, 2'd0, 6'd16, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_SETPOS, 3'd7, 1'b1, 2'd3, 6'd63, 8'hFF));
      issue_command(cmd(clcd_pkg::KIND_SETPOS, 3'd0, 1'b0, 2'd1, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_RAWCMD, 3'd0, 1'b0, 2'd0, 6'd0, 8'hFF));
      issue_command(cmd(clcd_pkg::KIND_RAWDATA, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(KIND_RSVD_14, 3'd7, 1'b1, 2'd3, 6'd63, 8'hFF));
      issue_command(cmd(KIND_RSVD_15, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_CLEAR, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_HOME, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      issue_command(cmd(clcd_pkg::KIND_CHAR, 3'd0, 1'b0, 2'd0, 6'd0, 8'h00));
      wait_drain();
   endtask

   function automatic clcd_pkg::req_type random_command();
      clcd_pkg::req_type c;
      int                pick;
      c.mode_flags = 3'($urandom_range(7));
      c.move_right = 1'($urandom_range(1));
      c.target_row = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
      c.target_col = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) :
                                                6'($urandom_range(COLUMNS - 1));
      c.byte_value = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 2)       c.kind = clcd_pkg::KIND_INIT;
      else if (pick < 10) c.kind = clcd_pkg::KIND_DISP_ON;
      else if (pick < 13) c.kind = clcd_pkg::KIND_DISP_OFF;
      else if (pick < 16) c.kind = clcd_pkg::KIND_CLEAR;
      else if (pick < 19) c.kind = clcd_pkg::KIND_HOME;
      else if (pick < 22) c.kind = clcd_pkg::KIND_CURS_ON;
      else if (pick < 25) c.kind = clcd_pkg::KIND_CURS_OFF;
      else if (pick < 28) c.kind = clcd_pkg::KIND_BLINK_ON;
      else if (pick < 31) c.kind = clcd_pkg::KIND_BLINK_OFF;
      else if (pick < 45) c.kind = clcd_pkg::KIND_SHIFT;
      else if (pick < 55) c.kind = clcd_pkg::KIND_SETPOS;
      else if (pick < 85) c.kind = clcd_pkg::KIND_CHAR;
      else if (pick < 91) c.kind = clcd_pkg::KIND_RAWCMD;
      else if (pick < 97) c.kind = clcd_pkg::KIND_RAWDATA;
      else                c.kind = $urandom_range(1) ? KIND_RSVD_15 : KIND_RSVD_14;
      return c;
   endfunction

   task automatic test_random_traffic(input int send_idle, input int recv_stall, input int count);
      clcd_pkg::req_type c;
      int                sent;
      int                len;
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(4) == 0) begin
            // write a run of characters from a legal position, often past the line end
            issue_command(cmd(clcd_pkg::KIND_SETPOS, 3'($urandom_range(7)),
                              1'($urandom_range(1)), 2'($urandom_range(1)),
                              6'($urandom_range(COLUMNS - 1)), 8'($urandom_range(255))));
            len = $urandom_range(3, 18);
            for (int i = 0; i < len; i++)
               issue_command(cmd(clcd_pkg::KIND_CHAR, 3'($urandom_range(7)),
                                 1'($urandom_range(1)), 2'($urandom_range(3)),
                                 6'($urandom_range(63)), 8'($urandom_range(255))));
            sent += len + 1;
         end else begin
            c = random_command();
            issue_command(c);
            if (c.kind <= clcd_pkg::KIND_RAWDATA)
               sent++;
         end
      end
      wait_drain();
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      @(posedge clock);
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++)
         issue_command(random_command());
      wait_drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      cur_row  = 1'b0;
      cur_col  = 0;
      cur_mode = 3'd0;
      test_directed_commands();
      test_random_traffic(0, 0, 100);
      test_random_traffic(45, 0, 100);
      test_random_traffic(0, 45, 100);
      test_random_traffic(16, 16, 100);
      test_backpressure();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
